[design/pse_pkg.sv]
// ----------------------------------------------------------------------------
// Printable string extractor package
// Shared types, payload structs and constants for the extractor blocks.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int RUN_BUFFER_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int DATA_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int MINLEN_W = 5;
    localparam int ROFS_W   = 32;

    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = MINLEN_W'(4);

    localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CHAR_DEL   = 8'h7F;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic [ROFS_W-1:0] run_offset;
        logic              is_last;
        logic              string_complete;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic emit_now;
        logic last_char;
    } t_status;

endpackage

[design/pse_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/pse_ctrl.sv]
// ----------------------------------------------------------------------------
// Printable string extractor controller
// Sequences byte intake and the character-by-character output of a piece.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pse_pkg::t_status i_status,
    output pse_pkg::t_cmd    o_cmd
);
    import pse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.accept = 1'b1;
                    if (i_status.emit_now) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_cmd.rd_en = 1'b1;
                n_state     = S_SHOW;
            end
            S_SHOW: begin
                if (i_out_ready) begin
                    if (i_status.last_char) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= (n_state == S_SHOW);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

endmodule

[design/pse_datapath.sv]
// ----------------------------------------------------------------------------
// Printable string extractor datapath
// Run buffer, run and file position counters, and the output piece registers.
// ----------------------------------------------------------------------------
module pse_datapath #(
    parameter int RUN_BUFFER  = pse_pkg::RUN_BUFFER_DEF,
    parameter int OFFSET_BITS = pse_pkg::OFFSET_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pse_pkg::MINLEN_W-1:0] i_cfg_wdata,
    input  pse_pkg::t_in_item         i_in_data,
    input  pse_pkg::t_cmd             i_cmd,
    output pse_pkg::t_status          o_status,
    output pse_pkg::t_out_item        o_out_data
);
    import pse_pkg::*;

    localparam int LEN_W = $clog2(RUN_BUFFER);
    localparam int CMP_W = (LEN_W > MINLEN_W) ? LEN_W : MINLEN_W;
    localparam logic [LEN_W-1:0] CUT_LEN = LEN_W'(RUN_BUFFER - 1);

    logic [MINLEN_W-1:0]    r_min_length;
    logic [LEN_W-1:0]       r_run_length;
    logic [OFFSET_BITS-1:0] r_run_start;
    logic [OFFSET_BITS-1:0] r_byte_pos;
    logic [LEN_W-1:0]       r_emit_len;
    logic                   r_emit_complete;
    logic [OFFSET_BITS-1:0] r_emit_offset;
    logic [LEN_W-1:0]       r_idx;

    logic [LEN_W-1:0]       n_run_length;
    logic [OFFSET_BITS-1:0] n_run_start;
    logic [OFFSET_BITS-1:0] n_byte_pos;
    logic [LEN_W-1:0]       len_inc;
    logic [LEN_W-1:0]       emit_len;
    logic                   emit_complete;
    logic                   emit_now;
    logic                   printable;
    logic [MINLEN_W-1:0]    need;
    logic [CHAR_W-1:0]      rdata;
    logic [63:0]            offset_wide;

    assign printable = ((i_in_data.data_byte >= CHAR_SPACE) &&
                        (i_in_data.data_byte < CHAR_DEL)) ||
                       (i_in_data.data_byte == CHAR_TAB);
    assign need      = (r_min_length == '0) ? MINLEN_W'(1) : r_min_length;
    assign len_inc   = r_run_length + LEN_W'(1);

    always_comb begin
        n_run_start   = r_run_start;
        n_run_length  = r_run_length;
        emit_len      = r_run_length;
        emit_complete = 1'b1;
        emit_now      = 1'b0;
        n_byte_pos    = i_in_data.last_byte ? '0 : r_byte_pos + OFFSET_BITS'(1);
        if (printable) begin
            if (r_run_length == '0) begin
                n_run_start = r_byte_pos;
            end
            emit_len = len_inc;
            if (len_inc == CUT_LEN) begin
                emit_complete = 1'b0;
                emit_now      = 1'b1;
                n_run_length  = '0;
            end else begin
                n_run_length = len_inc;
                if (i_in_data.last_byte) begin
                    emit_now     = (CMP_W'(len_inc) >= CMP_W'(need));
                    n_run_length = '0;
                end
            end
        end else begin
            emit_now     = (CMP_W'(r_run_length) >= CMP_W'(need));
            n_run_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RESET;
            r_run_length <= '0;
            r_run_start  <= '0;
            r_byte_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_length <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_run_length <= n_run_length;
                r_run_start  <= n_run_start;
                r_byte_pos   <= n_byte_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_emit_len      <= emit_len;
            r_emit_complete <= emit_complete;
            r_emit_offset   <= n_run_start;
            r_idx           <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + LEN_W'(1);
        end
    end

    pse_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RUN_BUFFER)
    ) u_run_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && printable),
        .i_waddr (r_run_length),
        .i_wdata (i_in_data.data_byte[CHAR_W-1:0]),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign offset_wide = 64'(r_emit_offset);

    assign o_status.emit_now  = emit_now;
    assign o_status.last_char = (r_idx == (r_emit_len - LEN_W'(1)));

    assign o_out_data.out_char        = rdata;
    assign o_out_data.run_offset      = offset_wide[ROFS_W-1:0];
    assign o_out_data.is_last         = o_status.last_char;
    assign o_out_data.string_complete = r_emit_complete;

endmodule

[design/printable_string_extractor.sv]
// ----------------------------------------------------------------------------
// Printable string extractor
// Collects runs of printable bytes from a file stream and emits them by char.
// ----------------------------------------------------------------------------
// A byte that emits nothing leaves intake ready for the next byte. A byte
// that completes a piece holds intake until the whole piece is shown: each
// character takes a read of the run buffer's single registered read port
// in S_READ and is then held in S_SHOW until the output side takes it. The
// run buffer needs no clearing after reset.
module printable_string_extractor #(
    parameter int RUN_BUFFER  = pse_pkg::RUN_BUFFER_DEF,
    parameter int OFFSET_BITS = pse_pkg::OFFSET_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pse_pkg::MINLEN_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pse_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pse_pkg::t_out_item           o_out_data
);
    import pse_pkg::*;

    t_cmd    cmd;
    t_status status;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pse_datapath #(
        .RUN_BUFFER  (RUN_BUFFER),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

[bench/printable_string_extractor_tb.sv]
// ----------------------------------------------------------------------------
// Printable string extractor testbench
// Drives byte streams through the extractor under random stalls on both
// channels, predicts emitted characters with a behavioral model of the run
// buffer or a directed row's typed result, and checks each output transfer
// against them in order. A directed table covers the edge cases first, then
// random files of printable runs and noise follow under a range of minimum lengths.
// ----------------------------------------------------------------------------
module printable_string_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    localparam int RUN_CAP    = RUN_BUFFER_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYC = 8;
    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 30;

    typedef enum {ROW_CFG, ROW_BYTE} t_row_kind;
    typedef enum {EXP_MODEL, EXP_NONE, EXP_ONE} t_exp_mode;

    typedef struct {
        t_row_kind         kind;
        logic [DATA_W-1:0] value;
        logic              last;
        int                reps;
        t_exp_mode         mode;
        t_out_item         res;
    } t_plan_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [MINLEN_W-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_item            in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_item;

    logic [CHAR_W-1:0]   run_chars [RUN_CAP];
    int                  run_len = 0;
    logic [ROFS_W-1:0]   run_start = '0;
    logic [ROFS_W-1:0]   byte_pos = '0;
    logic [MINLEN_W-1:0] min_len = MIN_LENGTH_RESET;

    t_out_item           fresh_chars[$];
    t_out_item           expected_chars[$];
    t_plan_row           plan[$];

    bit                  calm = 1'b0;
    int                  errors = 0;
    int                  bytes_sent = 0;
    int                  files_sent = 0;
    int                  chars_seen = 0;
    int                  strings_seen = 0;
    int                  cuts_seen = 0;
    int                  idle_cycles = 0;

    printable_string_extractor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    function automatic bit is_printable(logic [DATA_W-1:0] b);
        return (b >= CHAR_SPACE && b < CHAR_DEL) || b == CHAR_TAB;
    endfunction

    function automatic void emit_piece(bit complete);
        t_out_item r;
        for (int i = 0; i < run_len; i++) begin
            r.out_char        = run_chars[i];
            r.run_offset      = run_start;
            r.is_last         = (i == run_len - 1);
            r.string_complete = complete;
            fresh_chars.push_back(r);
        end
    endfunction

    function automatic void close_run();
        int need;
        need = (min_len == 0) ? 1 : int'(min_len);
        if (run_len >= need) begin
            emit_piece(1'b1);
        end
        run_len = 0;
    endfunction

    function automatic void predict_byte(t_in_item it);
        fresh_chars.delete();
        if (is_printable(it.data_byte)) begin
            if (run_len == 0) begin
                run_start = byte_pos;
            end
            if (run_len < RUN_CAP) begin
                run_chars[run_len] = it.data_byte[CHAR_W-1:0];
                run_len++;
            end
            if (run_len >= RUN_CAP - 1) begin
                emit_piece(1'b0);
                run_len = 0;
            end
        end else begin
            close_run();
        end
        byte_pos = byte_pos + 1'b1;
        if (it.last_byte) begin
            close_run();
            byte_pos = '0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_byte(input t_in_item it, input t_exp_mode mode,
                             input t_out_item typed_res);
        while (!calm && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        predict_byte(it);
        case (mode)
            EXP_MODEL: begin
                foreach (fresh_chars[i]) expected_chars.push_back(fresh_chars[i]);
            end
            EXP_ONE: begin
                expected_chars.push_back(typed_res);
            end
            default: begin
            end
        endcase
        bytes_sent++;
        if (it.last_byte) files_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_min_len(input logic [MINLEN_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        min_len    = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void add_row(t_row_kind kind, logic [DATA_W-1:0] value,
                                    logic last, int reps, t_exp_mode mode,
                                    t_out_item res);
        t_plan_row r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        r.reps  = reps;
        r.mode  = mode;
        r.res   = res;
        plan.push_back(r);
    endfunction

    function automatic logic [DATA_W-1:0] pick_printable();
        if ($urandom_range(15) == 0) return CHAR_TAB;
        return DATA_W'($urandom_range(int'(CHAR_SPACE), int'(CHAR_DEL) - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_stop();
        logic [DATA_W-1:0] b;
        do b = DATA_W'($urandom_range(255)); while (is_printable(b));
        return b;
    endfunction

    task automatic random_burst(input int n);
        int       sent;
        int       len;
        int       pick;
        bit       end_on_char;
        t_in_item it;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 72) begin
                pick = $urandom_range(99);
                len = (pick < 65) ? $urandom_range(1, 10) :
                      (pick < 88) ? $urandom_range(11, 28) : $urandom_range(29, 40);
                end_on_char = ($urandom_range(7) == 0);
                for (int i = 0; i < len; i++) begin
                    it.data_byte = pick_printable();
                    it.last_byte = end_on_char && (i == len - 1);
                    push_byte(it, EXP_MODEL, '0);
                    sent++;
                end
                if (!end_on_char) begin
                    it.data_byte = pick_stop();
                    it.last_byte = ($urandom_range(7) == 0);
                    push_byte(it, EXP_MODEL, '0);
                    sent++;
                end
            end else begin
                it.data_byte = DATA_W'($urandom_range(255));
                it.last_byte = ($urandom_range(15) == 0);
                push_byte(it, EXP_MODEL, '0);
                sent++;
            end
        end
    endtask

    always @(negedge clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            chars_seen++;
            if (out_item.is_last) begin
                if (out_item.string_complete) strings_seen++;
                else cuts_seen++;
            end
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h offset %0d last %b complete %b",
                    out_item.out_char, out_item.run_offset, out_item.is_last,
                    out_item.string_complete));
            end else begin
                want = expected_chars.pop_front();
                if (out_item.out_char !== want.out_char ||
                    out_item.run_offset !== want.run_offset ||
                    out_item.is_last !== want.is_last ||
                    out_item.string_complete !== want.string_complete) begin
                    report_mismatch($sformatf(
                        "got %h/%0d/%b/%b want %h/%0d/%b/%b (char/offset/last/complete)",
                        out_item.out_char, out_item.run_offset, out_item.is_last,
                        out_item.string_complete, want.out_char, want.run_offset,
                        want.is_last, want.string_complete));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL printable_string_extractor");
            $finish;
        end
    end

    initial begin
        int min_list [PHASES];
        min_list = '{1, 31, 4, 2, 0, 3, 6, 12, 1, 5};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A single character at reset length is too short to emit.
        add_row(ROW_BYTE, "A", 1'b1, 1, EXP_NONE, '0);
        add_row(ROW_BYTE, "a", 1'b0, 4, EXP_MODEL, '0);
        add_row(ROW_BYTE, 8'h00, 1'b1, 1, EXP_MODEL, '0);
        add_row(ROW_CFG, 8'd1, 1'b0, 1, EXP_MODEL, '0);
        add_row(ROW_BYTE, CHAR_SPACE, 1'b1, 1, EXP_ONE, t_out_item'{7'h20, 32'd0, 1'b1, 1'b1});
        add_row(ROW_BYTE, 8'h7E, 1'b1, 1, EXP_ONE, t_out_item'{7'h7E, 32'd0, 1'b1, 1'b1});
        add_row(ROW_BYTE, CHAR_TAB, 1'b1, 1, EXP_ONE, t_out_item'{7'h09, 32'd0, 1'b1, 1'b1});
        add_row(ROW_BYTE, CHAR_DEL, 1'b1, 1, EXP_NONE, '0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1, EXP_NONE, '0);
        add_row(ROW_BYTE, 8'h1F, 1'b0, 1, EXP_NONE, '0);
        add_row(ROW_BYTE, 8'h80, 1'b1, 1, EXP_NONE, '0);
        add_row(ROW_CFG, 8'd0, 1'b0, 1, EXP_MODEL, '0);
        add_row(ROW_BYTE, 8'h0A, 1'b0, 1, EXP_MODEL, '0);
        add_row(ROW_BYTE, "x", 1'b0, 1, EXP_MODEL, '0);
        add_row(ROW_BYTE, 8'h0A, 1'b1, 1, EXP_MODEL, '0);
        add_row(ROW_CFG, 8'd31, 1'b0, 1, EXP_MODEL, '0);
        add_row(ROW_BYTE, "q", 1'b0, 5, EXP_MODEL, '0);
        add_row(ROW_BYTE, 8'h00, 1'b1, 1, EXP_MODEL, '0);
        // The cut lands on the file's last byte, so the flush adds nothing.
        add_row(ROW_BYTE, "m", 1'b0, 30, EXP_MODEL, '0);
        add_row(ROW_BYTE, "n", 1'b1, 1, EXP_MODEL, '0);
        add_row(ROW_CFG, 8'd4, 1'b0, 1, EXP_MODEL, '0);
        add_row(ROW_BYTE, "z", 1'b0, 31, EXP_MODEL, '0);
        add_row(ROW_BYTE, "w", 1'b0, 3, EXP_MODEL, '0);
        add_row(ROW_BYTE, 8'hA0, 1'b1, 1, EXP_MODEL, '0);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                write_min_len(plan[r].value[MINLEN_W-1:0]);
            end else begin
                repeat (plan[r].reps) begin
                    push_byte(t_in_item'{plan[r].value, plan[r].last}, plan[r].mode,
                              plan[r].res);
                end
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_min_len((p == PHASES - 1) ? MINLEN_W'($urandom_range(1, 31))
                                            : MINLEN_W'(min_list[p]));
            calm = (p == 3);
            random_burst(PHASE_ITEMS);
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d expected chars never arrived",
                                      expected_chars.size()));
        end

        $display("Run covered %0d bytes in %0d files and %0d output characters,",
                 bytes_sent, files_sent, chars_seen);
        $display("with %0d complete strings, %0d cut chunks and %0d mismatches.",
                 strings_seen, cuts_seen, errors);
        if (errors == 0) begin
            $display("PASS printable_string_extractor");
        end else begin
            $display("FAIL printable_string_extractor");
        end
        $finish;
    end

endmodule
